@@ rtl/sfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdt_pkg
// Shared types, constants, microcode table and helper functions for the
// signed fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package sfdt_pkg;

    localparam int VALUE_W = 16;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 3;
    localparam int PC_W    = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    localparam logic [CFG_W-1:0]  INT_DIGITS_RST  = 3'd3;
    localparam logic [CFG_W-1:0]  FRAC_DIGITS_RST = 3'd2;
    localparam logic [CHAR_W-1:0] SEPARATOR_RST   = 8'd46;

    // Digit positions with a nonzero weight for a 16-bit magnitude
    localparam logic [3:0] WEIGHTED_POS = 4'd5;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_INT_DIGITS  = 2'd0;
    localparam logic [1:0] REG_FRAC_DIGITS = 2'd1;
    localparam logic [1:0] REG_SEPARATOR   = 2'd2;

    // Microprogram step addresses
    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [PC_W-1:0] STEP_SIGN = 3'd1;
    localparam logic [PC_W-1:0] STEP_INT  = 3'd2;
    localparam logic [PC_W-1:0] STEP_SEP  = 3'd3;
    localparam logic [PC_W-1:0] STEP_FRAC = 3'd4;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SIGN,
        EMIT_DIGIT,
        EMIT_SEP
    } emit_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INT,
        CNT_FRAC
    } cnt_ld_t;

    // One control word of the microprogram
    typedef struct packed {
        logic            take_in;
        emit_t           emit;
        cnt_ld_t         cnt_ld;
        logic            loop;
        logic            fin;
        logic [PC_W-1:0] next_pc;
    } uword_t;

    typedef struct packed {
        logic [CFG_W-1:0]  ni;
        logic [CFG_W-1:0]  nf;
        logic [CHAR_W-1:0] sep;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  emit;
        emit_t sel;
        logic  last;
    } ctrl_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE: w = '{1'b1, EMIT_NONE,  CNT_KEEP, 1'b0, 1'b0, STEP_SIGN};
            STEP_SIGN: w = '{1'b0, EMIT_SIGN,  CNT_INT,  1'b0, 1'b0, STEP_INT};
            STEP_INT:  w = '{1'b0, EMIT_DIGIT, CNT_KEEP, 1'b1, 1'b0, STEP_SEP};
            STEP_SEP:  w = '{1'b0, EMIT_SEP,   CNT_FRAC, 1'b0, 1'b0, STEP_FRAC};
            STEP_FRAC: w = '{1'b0, EMIT_DIGIT, CNT_KEEP, 1'b1, 1'b1, STEP_IDLE};
            default:   w = '{1'b0, EMIT_NONE,  CNT_KEEP, 1'b0, 1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_int(input logic [CFG_W-1:0] v);
        if (v == 3'd0)
            return 3'd1;
        else if (v > 3'd5)
            return 3'd5;
        else
            return v;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_frac(input logic [CFG_W-1:0] v);
        if (v == 3'd0)
            return 3'd1;
        else if (v > 3'd4)
            return 3'd4;
        else
            return v;
    endfunction

    function automatic logic [VALUE_W:0] pow10(input logic [2:0] n);
        logic [VALUE_W:0] r;
        unique case (n)
            3'd0:    r = 17'd1;
            3'd1:    r = 17'd10;
            3'd2:    r = 17'd100;
            3'd3:    r = 17'd1000;
            3'd4:    r = 17'd10000;
            default: r = 17'd100000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/sfdt_if.sv @@
// ----------------------------------------------------------------------------
// sfdt_in_if / sfdt_out_if
// Valid/ready channels: fixed-point values in, text characters out.
// ----------------------------------------------------------------------------
interface sfdt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfdt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sfdt_out_if;
    logic                        valid;
    logic                        ready;
    logic [sfdt_pkg::CHAR_W-1:0] char_code;
    logic                        last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/sfdt_cfg.sv @@
// ----------------------------------------------------------------------------
// sfdt_cfg
// APB register file: digit counts and separator, clamped for the datapath.
// ----------------------------------------------------------------------------
module sfdt_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfdt_pkg::ADDR_W-1:0]   paddr,
    input  logic [sfdt_pkg::DATA_W-1:0]   pwdata,
    output logic [sfdt_pkg::DATA_W-1:0]   prdata,
    output sfdt_pkg::cfg_t                cfg
);

    logic [sfdt_pkg::CFG_W-1:0]  int_digits_reg;
    logic [sfdt_pkg::CFG_W-1:0]  frac_digits_reg;
    logic [sfdt_pkg::CHAR_W-1:0] separator_reg;
    logic                        wr_en;
    logic [1:0]                  idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_digits_reg  <= sfdt_pkg::INT_DIGITS_RST;
            frac_digits_reg <= sfdt_pkg::FRAC_DIGITS_RST;
            separator_reg   <= sfdt_pkg::SEPARATOR_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                sfdt_pkg::REG_INT_DIGITS:  int_digits_reg  <= pwdata[2:0];
                sfdt_pkg::REG_FRAC_DIGITS: frac_digits_reg <= pwdata[2:0];
                sfdt_pkg::REG_SEPARATOR:   separator_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sfdt_pkg::REG_INT_DIGITS:  prdata = {29'd0, int_digits_reg};
            sfdt_pkg::REG_FRAC_DIGITS: prdata = {29'd0, frac_digits_reg};
            sfdt_pkg::REG_SEPARATOR:   prdata = {24'd0, separator_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.ni  = sfdt_pkg::clamp_int(int_digits_reg);
    assign cfg.nf  = sfdt_pkg::clamp_frac(frac_digits_reg);
    assign cfg.sep = separator_reg;

endmodule

@@ rtl/sfdt_seq.sv @@
// ----------------------------------------------------------------------------
// sfdt_seq
// Microcode sequencer: step counter, control ROM and digit loop counter.
// ----------------------------------------------------------------------------
module sfdt_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  sfdt_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  logic           out_free,
    output logic           in_ready,
    output sfdt_pkg::ctrl_t ctrl
);

    logic [sfdt_pkg::PC_W-1:0]  pc_reg;
    logic [sfdt_pkg::PC_W-1:0]  pc_next;
    logic [sfdt_pkg::CFG_W-1:0] cnt_reg;
    logic [sfdt_pkg::CFG_W-1:0] cnt_next;
    sfdt_pkg::uword_t           word;
    logic                       fire;
    logic                       emitting;

    assign word     = sfdt_pkg::ucode(pc_reg);
    assign emitting = (word.emit != sfdt_pkg::EMIT_NONE);
    assign fire     = word.take_in ? in_valid : (emitting && out_free);
    assign in_ready = word.take_in;

    assign ctrl.load = word.take_in && in_valid;
    assign ctrl.emit = emitting && out_free;
    assign ctrl.sel  = word.emit;
    assign ctrl.last = word.fin && (cnt_reg == 3'd0);

    always_comb
    begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        if (fire)
        begin
            if (word.loop && (cnt_reg != 3'd0))
            begin
                cnt_next = cnt_reg - 3'd1;
            end
            else
            begin
                pc_next = word.next_pc;
                unique case (word.cnt_ld)
                    sfdt_pkg::CNT_INT:  cnt_next = cfg.ni - 3'd1;
                    sfdt_pkg::CNT_FRAC: cnt_next = cfg.nf - 3'd1;
                    default:            cnt_next = cnt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= sfdt_pkg::STEP_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.last) |=> (pc_reg == sfdt_pkg::STEP_IDLE))
        else $error("final character did not return the sequencer to idle");
    a_load_to_sign: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (pc_reg == sfdt_pkg::STEP_SIGN))
        else $error("accepted value did not start with the sign step");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("digit loop counter out of range");
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !ctrl.emit)
        else $error("character emitted while waiting for input");
`endif

endmodule

@@ rtl/sfdt_dp.sv @@
// ----------------------------------------------------------------------------
// sfdt_dp
// Datapath: magnitude and overflow capture, one decimal digit per step,
// character select and output register.
// ----------------------------------------------------------------------------
module sfdt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfdt_pkg::cfg_t                      cfg,
    input  sfdt_pkg::ctrl_t                     ctrl,
    input  logic signed [sfdt_pkg::VALUE_W-1:0] value,
    input  logic                                out_ready,
    output logic                                out_free,
    output logic                                out_valid,
    output logic [sfdt_pkg::CHAR_W-1:0]         char_code,
    output logic                                last
);

    logic [sfdt_pkg::VALUE_W-1:0] rem_reg;
    logic [sfdt_pkg::VALUE_W-1:0] mag;
    logic                         neg_reg;
    logic                         ovf_reg;
    logic                         ovf;
    logic [3:0]                   pos_reg;
    logic [3:0]                   total;
    logic [sfdt_pkg::VALUE_W:0]   weight;
    logic [sfdt_pkg::VALUE_W:0]   thr [10];
    logic [3:0]                   digit;
    logic [sfdt_pkg::CHAR_W-1:0]  ch;
    logic                         out_valid_reg;
    logic [sfdt_pkg::CHAR_W-1:0]  char_reg;
    logic                         last_reg;

    // Two's-complement magnitude; the most negative value wraps to 32768
    assign mag   = value[sfdt_pkg::VALUE_W-1] ? (16'd0 - value) : value;
    assign total = {1'b0, cfg.ni} + {1'b0, cfg.nf};
    assign ovf   = (total < sfdt_pkg::WEIGHTED_POS)
                   && ({1'b0, mag} >= sfdt_pkg::pow10(total[2:0]));

    assign weight = sfdt_pkg::pow10(pos_reg[2:0]);

    always_comb
    begin
        for (int d = 0; d < 10; d++)
            thr[d] = 17'(weight * 17'(d));
        digit = 4'd0;
        if (pos_reg < sfdt_pkg::WEIGHTED_POS)
        begin
            for (int d = 1; d < 10; d++)
                if ({1'b0, rem_reg} >= thr[d])
                    digit = 4'(d);
        end
    end

    always_comb
    begin
        unique case (ctrl.sel)
            sfdt_pkg::EMIT_SIGN:  ch = neg_reg ? sfdt_pkg::CH_MINUS : sfdt_pkg::CH_ZERO;
            sfdt_pkg::EMIT_DIGIT: ch = sfdt_pkg::CH_ZERO + {4'd0, digit};
            sfdt_pkg::EMIT_SEP:   ch = cfg.sep;
            default:              ch = sfdt_pkg::CH_ZERO;
        endcase
        if (ovf_reg)
            ch = sfdt_pkg::CH_STAR;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= mag;
            neg_reg <= value[sfdt_pkg::VALUE_W-1];
            ovf_reg <= ovf;
            pos_reg <= total - 4'd1;
        end
        else if (ctrl.emit && (ctrl.sel == sfdt_pkg::EMIT_DIGIT))
        begin
            rem_reg <= rem_reg - thr[digit][sfdt_pkg::VALUE_W-1:0];
            pos_reg <= pos_reg - 4'd1;
        end
        if (ctrl.emit)
        begin
            char_reg <= ch;
            last_reg <= ctrl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

@@ rtl/signed_fixed_point_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// signed_fixed_point_to_decimal_text
// Converts a signed 16-bit fixed-point value into fixed-width decimal text,
// one ASCII character per transfer.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  -------------------------------------
//  number   in   valid / ready   value[15:0] signed, scaled by 10^frac
//  text     out  valid / ready   char_code[7:0], last
//  apb      in   psel/penable    int_digits, frac_digits, separator_char
//
//  One value takes one accept step, then one microcode step per character.
//  The sequencer handles one value at a time; the next value is taken
//  while the final character still waits in the output register.
//  A stalled text sink holds the sequencer on its current step.
//  Reset (rst_n, async low) returns the sequencer to its idle step and
//  restores int_digits 3, frac_digits 2, separator '.'.
//
// ----------------------------------------------------------------------------
module signed_fixed_point_to_decimal_text (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfdt_pkg::ADDR_W-1:0] paddr,
    input  logic [sfdt_pkg::DATA_W-1:0] pwdata,
    output logic [sfdt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    sfdt_in_if.sink                     number,
    sfdt_out_if.source                  text
);

    sfdt_pkg::cfg_t  cfg;
    sfdt_pkg::ctrl_t ctrl;
    logic            out_free;

    // APB is zero wait state
    assign pready = 1'b1;

    // Register file: writes land on the access phase
    sfdt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Sequencer: step counter walks sign, integer digits, separator,
    // fraction digits; character steps advance only when the output register
    // can take a character
    sfdt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (number.valid),
        .out_free (out_free),
        .in_ready (number.ready),
        .ctrl     (ctrl)
    );

    // Datapath: extract one digit of the remaining magnitude per digit step
    sfdt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ctrl      (ctrl),
        .value     (number.value),
        .out_ready (text.ready),
        .out_free  (out_free),
        .out_valid (text.valid),
        .char_code (text.char_code),
        .last      (text.last)
    );

endmodule
